### hw/rtl/sob_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sob_pkg
// shared types, constants and helpers for the source-over blend pipeline
// ----------------------------------------------------------------------------
package sob_pkg;

  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PROD_W     = 16;   // 8x8 product
  localparam int WPROD_W    = 24;   // 16x8 product
  localparam int NUM_W      = 25;   // channel numerator
  localparam int DIV_W      = 16;   // result alpha times 255
  localparam int Q_W        = 9;    // quotient bits, top bit flags overflow

  localparam logic [CH_W-1:0]   CH_MAX     = 8'hFF;
  localparam logic [CH_W-1:0]   CH_ZERO    = 8'h00;
  localparam logic [PROD_W-1:0] HALF_ROUND = 16'd127;

  // how a request leaves the pipeline
  typedef enum logic [1:0] {
    MODE_BLEND = 2'd0,
    MODE_SRC   = 2'd1,
    MODE_DST   = 2'd2
  } sob_mode_t;

  // sideband carried alongside the division
  typedef struct packed {
    sob_mode_t          mode;
    logic [PIX_W-1:0]   pixel;   // pass-through pixel for opaque / clear source
    logic [CH_W-1:0]    oa;      // result alpha
  } sob_side_t;

  // one division stage worth of state
  typedef struct packed {
    logic [NUM_CH-1:0][NUM_W-1:0] rem;
    logic [NUM_CH-1:0][Q_W-1:0]   quo;
    logic [DIV_W-1:0]             divisor;
    sob_side_t                    side;
  } sob_div_t;

  // floor(x / 255) for x up to 65279
  function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] sum;
    sum = {1'b0, x} + {9'd0, x[PROD_W-1:CH_W]} + 17'd1;
    return sum[PROD_W-1:CH_W];
  endfunction

  // x * 255 as shift and subtract
  function automatic logic [WPROD_W-1:0] mul255(input logic [PROD_W-1:0] x);
    return {x, 8'd0} - {8'd0, x};
  endfunction

endpackage

### hw/rtl/source_over_alpha_blend_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_over_alpha_blend_unit
// source-over blend of straight-alpha ARGB8888 pixels, fully pipelined
// ----------------------------------------------------------------------------
// channel   dir  width  contents
// s_axis    in   64     dest_pixel [31:0], source_pixel [63:32]
// m_axis    out  32     blended_pixel [31:0]
//
// one pixel per clock sustained while m_axis_tready stays high; the path from
// request to output register is 3 prep stages, 9 divider stages and 1 output
// stage, the channel divider resolving one quotient bit per stage.
// rst is synchronous and clears only the valid bits.
// each stage advances when it is empty or the next one advances, so a
// stall at m_axis fills bubbles before s_axis_tready drops.
// ----------------------------------------------------------------------------
module source_over_alpha_blend_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // dest_pixel [31:0], source_pixel [63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // blended_pixel [31:0]
);

  logic              prep_valid, prep_ready;
  sob_pkg::sob_div_t prep_data;
  logic              div_valid, div_ready;
  sob_pkg::sob_div_t div_data;
  logic              out_en;
  logic [sob_pkg::PIX_W-1:0] result;
  logic [sob_pkg::CH_W-1:0]  ch [sob_pkg::NUM_CH];

  // alpha and numerator stages
  sob_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .dst       (s_axis_tdata[31:0]),
    .src       (s_axis_tdata[63:32]),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_data  (prep_data)
  );

  // channel division
  sob_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  // saturate each channel quotient
  always_comb begin
    for (int c = 0; c < sob_pkg::NUM_CH; c++) begin
      ch[c] = div_data.quo[c][sob_pkg::Q_W-1] ? sob_pkg::CH_MAX
                                               : div_data.quo[c][sob_pkg::CH_W-1:0];
    end
  end

  // pick blend, pass-through or zero alpha result
  always_comb begin
    case (div_data.side.mode) inside
      sob_pkg::MODE_SRC,
      sob_pkg::MODE_DST: begin
        result = div_data.side.pixel;
      end
      sob_pkg::MODE_BLEND: begin
        if (div_data.side.oa == sob_pkg::CH_ZERO) begin
          result = '0;
        end else begin
          result = {div_data.side.oa, ch[2], ch[1], ch[0]};
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  // output register
  assign out_en    = !m_axis_tvalid || m_axis_tready;
  assign div_ready = out_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_en) begin
      m_axis_tvalid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      m_axis_tdata <= result;
    end
  end

  // backpressure only comes from a held output
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // blend path always has a nonzero result alpha
  assert property (@(posedge clk) disable iff (rst)
    (div_valid && div_data.side.mode == sob_pkg::MODE_BLEND) |-> div_data.side.oa != 8'd0)
    else $error("zero result alpha in blend path");

  // divisor stays tied to the result alpha
  assert property (@(posedge clk) disable iff (rst)
    (div_valid && div_data.side.mode == sob_pkg::MODE_BLEND)
      |-> div_data.divisor == sob_pkg::DIV_W'(sob_pkg::mul255({8'd0, div_data.side.oa})))
    else $error("divisor lost track of result alpha");

  // nothing comes out right after reset
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

### hw/rtl/sob_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sob_prep
// three stages: alpha product, result alpha and channel products, numerators
// ----------------------------------------------------------------------------
module sob_prep (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sob_pkg::PIX_W-1:0]       dst,
  input  logic [sob_pkg::PIX_W-1:0]       src,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sob_pkg::sob_div_t               out_data
);

  // stage 1 registers
  logic                              v1;
  logic [sob_pkg::PIX_W-1:0]         dst1;
  logic [sob_pkg::PIX_W-1:0]         src1;
  logic [sob_pkg::PROD_W-1:0]        dainv1;
  sob_pkg::sob_mode_t                mode1;

  // stage 2 registers
  logic                                              v2;
  logic [sob_pkg::CH_W-1:0]                          oa2;
  logic [sob_pkg::NUM_CH-1:0][sob_pkg::PROD_W-1:0]   ps2;
  logic [sob_pkg::NUM_CH-1:0][sob_pkg::WPROD_W-1:0]  pd2;
  logic [sob_pkg::PIX_W-1:0]                         pix2;
  sob_pkg::sob_mode_t                                mode2;

  // stage 3 registers
  logic                  v3;
  sob_pkg::sob_div_t     d3;

  logic en1, en2, en3;
  logic [sob_pkg::CH_W-1:0] sa_in, da_in, sa1;
  sob_pkg::sob_mode_t mode_in;

  // per-stage advance, a bubble can always be filled
  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign sa_in = src[31:24];
  assign da_in = dst[31:24];
  assign sa1   = src1[31:24];

  // classify the source alpha
  always_comb begin
    if (sa_in == sob_pkg::CH_MAX) begin
      mode_in = sob_pkg::MODE_SRC;
    end else if (sa_in == sob_pkg::CH_ZERO) begin
      mode_in = sob_pkg::MODE_DST;
    end else begin
      mode_in = sob_pkg::MODE_BLEND;
    end
  end

  // stage 1: destination alpha times inverse source alpha
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      dst1   <= dst;
      src1   <= src;
      dainv1 <= {8'd0, da_in} * {8'd0, sob_pkg::CH_MAX - sa_in};
      mode1  <= mode_in;
    end
  end

  // stage 2: result alpha and per-channel products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      oa2   <= sa1 + sob_pkg::div255(dainv1 + sob_pkg::HALF_ROUND);
      mode2 <= mode1;
      pix2  <= (mode1 == sob_pkg::MODE_SRC) ? src1 : dst1;
      for (int c = 0; c < sob_pkg::NUM_CH; c++) begin
        ps2[c] <= {8'd0, src1[c*sob_pkg::CH_W +: sob_pkg::CH_W]} * {8'd0, sa1};
        pd2[c] <= {8'd0, dainv1} * {16'd0, dst1[c*sob_pkg::CH_W +: sob_pkg::CH_W]};
      end
    end
  end

  // stage 3: numerators and divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int c = 0; c < sob_pkg::NUM_CH; c++) begin
        d3.rem[c] <= {1'b0, sob_pkg::mul255(ps2[c])} + {1'b0, pd2[c]};
        d3.quo[c] <= '0;
      end
      d3.divisor    <= sob_pkg::DIV_W'(sob_pkg::mul255({8'd0, oa2}));
      d3.side.mode  <= mode2;
      d3.side.pixel <= pix2;
      d3.side.oa    <= oa2;
    end
  end

  assign out_valid = v3;
  assign out_data  = d3;

endmodule

### hw/rtl/sob_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sob_div
// restoring divider, one quotient bit per stage for all three channels
// ----------------------------------------------------------------------------
module sob_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sob_pkg::sob_div_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sob_pkg::sob_div_t    out_data
);

  logic              v  [sob_pkg::Q_W+1];
  sob_pkg::sob_div_t d  [sob_pkg::Q_W+1];
  logic              en [sob_pkg::Q_W+1];

  assign v[0]  = in_valid;
  assign d[0]  = in_data;
  assign en[0] = en[1];
  assign en[sob_pkg::Q_W] = !v[sob_pkg::Q_W] || out_ready;

  for (genvar i = 1; i <= sob_pkg::Q_W; i++) begin : g_stage
    localparam int SH = sob_pkg::Q_W - i;

    logic [sob_pkg::NUM_W-1:0] dsh;
    sob_pkg::sob_div_t         nxt;

    if (i < sob_pkg::Q_W) begin : g_en
      assign en[i] = !v[i] || en[i+1];
    end

    // divisor aligned to this quotient bit
    assign dsh = sob_pkg::NUM_W'(d[i-1].divisor) << SH;

    // trial subtract per channel
    always_comb begin
      nxt = d[i-1];
      for (int c = 0; c < sob_pkg::NUM_CH; c++) begin
        if (d[i-1].rem[c] >= dsh) begin
          nxt.rem[c]     = d[i-1].rem[c] - dsh;
          nxt.quo[c][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en[i]) begin
        v[i] <= v[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        d[i] <= nxt;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[sob_pkg::Q_W];
  assign out_data  = d[sob_pkg::Q_W];

endmodule

### verif/source_over_alpha_blend_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_over_alpha_blend_unit_tb
// drives destination/source pixel pairs into the blend unit and checks every
// blended pixel against a hand-written or in-bench source-over answer; a short
// corner table runs first, then random pixel pairs under changing back-pressure
// ----------------------------------------------------------------------------
module source_over_alpha_blend_unit_tb;

  localparam int CH_FULL     = 255;
  localparam int ROUND_BIAS  = 127;
  localparam int RANDOM_REQS = 500;
  localparam int DRAIN_CYC   = 40;   // extra drain after the last check
  localparam int HOLD_CYC    = 120;  // long output stall, fills the pipeline

  // one pixel pair plus an optional hand-written answer
  typedef struct {
    logic [31:0] dest;
    logic [31:0] src;
    bit          known;
    logic [31:0] blended;
  } blend_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;    // dest_pixel [31:0], source_pixel [63:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // blended_pixel [31:0]

  blend_row_t  pixel_rows[$];
  blend_row_t  corner_rows[18];
  logic [31:0] blended_q[$];
  int          sent_count = 0;
  int          checked_count = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          failed = 1'b0;

  source_over_alpha_blend_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // straight-alpha source-over of one pixel pair
  function automatic logic [31:0] source_over(input logic [31:0] dest,
                                              input logic [31:0] src);
    int unsigned     sa;
    int unsigned     da;
    int unsigned     inv;
    int unsigned     oa;
    int              sh;
    longint unsigned num;
    longint unsigned q;
    logic [31:0]     px;
    sa = src[31:24];
    if (sa == CH_FULL) return src;
    if (sa == 0) return dest;
    da  = dest[31:24];
    inv = CH_FULL - sa;
    oa  = sa + (da * inv + ROUND_BIAS) / CH_FULL;
    if (oa == 0) return 32'd0;
    px = '0;
    px[31:24] = oa[7:0];
    for (int k = 0; k < 3; k++) begin
      sh  = 16 - 8 * k;
      num = longint'(src[sh +: 8]) * sa * CH_FULL + longint'(dest[sh +: 8]) * da * inv;
      q   = num / (oa * CH_FULL);
      if (q > CH_FULL) q = CH_FULL;
      px[sh +: 8] = q[7:0];
    end
    return px;
  endfunction

  // random pair, biased toward the interesting alpha corners
  function automatic blend_row_t random_row();
    blend_row_t  r;
    int unsigned pick;
    r.dest    = $urandom();
    r.src     = $urandom();
    r.known   = 1'b0;
    r.blended = '0;
    pick      = $urandom_range(0, 99);
    if (pick < 10) begin
      r.src[31:24] = 8'h00;
    end else if (pick < 20) begin
      r.src[31:24] = 8'hFF;
    end else if (pick < 30) begin
      r.dest[31:24] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    end else if (pick < 45) begin
      // saturated colours probe the channel clamp
      r.dest[23:0] = 24'hFFFFFF;
      r.src[23:0]  = 24'hFFFFFF;
    end else if (pick < 55) begin
      r.src[31:24] = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 3))
                                                 : 8'($urandom_range(252, 254));
    end
    return r;
  endfunction

  // request side: offer pixels, record expectations on acceptance
  always @(posedge clk) begin
    int gap_pct;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (pixel_rows[sent_count].known)
          blended_q.push_back(pixel_rows[sent_count].blended);
        else
          blended_q.push_back(source_over(pixel_rows[sent_count].dest,
                                          pixel_rows[sent_count].src));
        sent_count++;
      end
      gap_pct = (sent_count * 3 < pixel_rows.size())     ? 12 :
                (sent_count * 3 < 2 * pixel_rows.size()) ? 70 : 0;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sent_count < pixel_rows.size() && $urandom_range(0, 99) >= gap_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {pixel_rows[sent_count].src, pixel_rows[sent_count].dest};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side: check each blended pixel, apply back-pressure
  always @(posedge clk) begin
    int stall_pct;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (blended_q.size() == 0) begin
          $error("unexpected blended_pixel %08h with no request pending", m_axis_tdata);
          failed = 1'b1;
        end else begin
          if (m_axis_tdata !== blended_q[0]) begin
            $error("blended_pixel mismatch: expected %08h, actual %08h",
                   blended_q[0], m_axis_tdata);
            failed = 1'b1;
          end
          void'(blended_q.pop_front());
          checked_count++;
        end
      end
      stall_pct = (checked_count * 3 < pixel_rows.size())     ? 70 :
                  (checked_count * 3 < 2 * pixel_rows.size()) ? 12 : 0;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && checked_count * 4 >= 3 * pixel_rows.size()) begin
        // one long stall while the sender keeps offering
        hold_done = 1'b1;
        hold_left = HOLD_CYC - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // stimulus build, reset, drain and verdict
  initial begin
    // corner table: transparent, opaque, empty destination, edges of alpha
    corner_rows[0]  = '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000};
    corner_rows[1]  = '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF};
    corner_rows[2]  = '{32'h1234_5678, 32'h00AB_CDEF, 1'b1, 32'h1234_5678};
    corner_rows[3]  = '{32'hFFFF_FFFF, 32'hFF00_0000, 1'b1, 32'hFF00_0000};
    corner_rows[4]  = '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF};
    corner_rows[5]  = '{32'h89AB_CDEF, 32'hFF12_3456, 1'b1, 32'hFF12_3456};
    corner_rows[6]  = '{32'h0000_0000, 32'h01FF_FFFF, 1'b1, 32'h01FF_FFFF};
    corner_rows[7]  = '{32'h00FF_FFFF, 32'h8010_2030, 1'b1, 32'h8010_2030};
    corner_rows[8]  = '{32'h0000_0000, 32'hFE00_0000, 1'b1, 32'hFE00_0000};
    corner_rows[9]  = '{32'hFFFF_FFFF, 32'h0100_0000, 1'b0, 32'h0};
    corner_rows[10] = '{32'hFFFF_FFFF, 32'hFEFF_FFFF, 1'b0, 32'h0};
    corner_rows[11] = '{32'hFF00_FF00, 32'h80FF_00FF, 1'b0, 32'h0};
    corner_rows[12] = '{32'h80FF_FFFF, 32'h01FF_FFFF, 1'b0, 32'h0};
    corner_rows[13] = '{32'h01FF_FFFF, 32'h01FF_FFFF, 1'b0, 32'h0};
    corner_rows[14] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0};
    corner_rows[15] = '{32'hFF00_0000, 32'h7FFF_FFFF, 1'b0, 32'h0};
    corner_rows[16] = '{32'hAA55_AA55, 32'h55AA_55AA, 1'b0, 32'h0};
    corner_rows[17] = '{32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'h0};
    foreach (corner_rows[i])
      pixel_rows.push_back(corner_rows[i]);
    for (int i = 0; i < RANDOM_REQS; i++)
      pixel_rows.push_back(random_row());

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (sent_count < pixel_rows.size() || checked_count < pixel_rows.size())
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (blended_q.size() != 0) begin
      $error("%0d blended pixels never arrived", blended_q.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

### source_over_alpha_blend_unit.f
hw/rtl/sob_pkg.sv
hw/rtl/sob_prep.sv
hw/rtl/sob_div.sv
hw/rtl/source_over_alpha_blend_unit.sv
verif/source_over_alpha_blend_unit_tb.sv
